[design/mflf_pkg.sv]
// Package for the most frequent label finder.
// Holds the widths, store entry layout, control types and state encoding
// shared by every file of the block; it depends on nothing else.
package mflf_pkg;

	localparam int CELL_LABEL_W = 16;
	localparam int LABEL_BITS   = 16;
	localparam int COUNT_BITS   = 17;
	localparam int ORDER_BITS   = LABEL_BITS;
	localparam int EPOCH_BITS   = 8;

	typedef logic [LABEL_BITS-1:0] label_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [ORDER_BITS-1:0] order_t;
	typedef logic [EPOCH_BITS-1:0] epoch_t;

	localparam count_t COUNT_MAX   = '1;
	localparam epoch_t EPOCH_FIRST = epoch_t'(1);
	localparam epoch_t EPOCH_LAST  = '1;
	localparam epoch_t EPOCH_STALE = '0;

	// One entry of the per-label store. An entry counts as seen in the
	// current set only when its epoch equals the running set epoch.
	typedef struct packed {
		epoch_t epoch;
		count_t count;
		order_t order;
	} entry_t;

	typedef struct packed {
		logic   we;
		label_t addr;
		entry_t data;
	} wr_req_t;

	typedef struct packed {
		logic   run;
		epoch_t epoch;
	} ctrl_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

endpackage

[design/mflf_ifs.sv]
// Valid/ready channel interfaces for cells in and results out.
// Depends on mflf_pkg for the field widths.
interface mflf_cell_if import mflf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CELL_LABEL_W-1:0] cell_label;
	logic                    last_cell;

	modport source (output valid, output cell_label, output last_cell, input ready);
	modport sink (input valid, input cell_label, input last_cell, output ready);
endinterface

interface mflf_result_if import mflf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CELL_LABEL_W-1:0] largest_label;
	logic [COUNT_BITS-1:0]   largest_count;

	modport source (output valid, output largest_label, output largest_count, input ready);
	modport sink (input valid, input largest_label, input largest_count, output ready);
endinterface

[design/mflf_label_ram.sv]
// Per-label store: one write port and one read port with registered data.
// Depends on mflf_pkg for the entry layout and address width.
module mflf_label_ram import mflf_pkg::*; (
	input  logic   clk,
	input  logic   we,
	input  label_t waddr,
	input  entry_t wdata,
	input  logic   re,
	input  label_t raddr,
	output entry_t rdata
);

	entry_t mem [2**LABEL_BITS];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/mflf_ctrl.sv]
// Block control: clearing sweep of the label store and the set epoch.
// Depends on mflf_pkg for the state type, control struct and write request.
module mflf_ctrl import mflf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    set_done,
	output ctrl_t   ctrl,
	output wr_req_t clr_wr
);

	state_t state_q;
	state_t state_d;
	label_t clr_addr_q;
	epoch_t epoch_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == '1) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (set_done && epoch_q == EPOCH_LAST) begin
					state_d = ST_CLEAR;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctrl.run     = (state_q == ST_RUN);
		ctrl.epoch   = epoch_q;
		clr_wr.we    = (state_q == ST_CLEAR);
		clr_wr.addr  = clr_addr_q;
		clr_wr.data  = '{epoch: EPOCH_STALE, count: '0, order: '0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			epoch_q    <= EPOCH_FIRST;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			// Epoch values come back only after a full sweep has marked every
			// entry stale again.
			if (set_done) begin
				epoch_q <= (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + 1'b1;
			end
		end
	end

endmodule

[design/mflf_tally.sv]
// Count update stage: read-modify-write of the label store with forwarding,
// running winner tracking and the result register.
// Depends on mflf_pkg and the channel interfaces in mflf_ifs.sv.
module mflf_tally import mflf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ctrl_t         ctrl,
	mflf_cell_if.sink     cells,
	mflf_result_if.source result,
	output logic          rd_en,
	output label_t        rd_addr,
	input  entry_t        rd_data,
	output wr_req_t       wr_req,
	output logic          set_done
);

	logic   valid_s1;
	label_t label_s1;
	logic   last_s1;

	logic   fwd_valid_q;
	label_t fwd_label_q;
	entry_t fwd_data_q;

	label_t best_label_q;
	count_t best_count_q;
	order_t best_order_q;
	order_t next_order_q;

	logic   out_valid_q;
	label_t out_label_q;
	count_t out_count_q;

	logic   cell_acc;
	logic   out_free;
	logic   advance;
	logic   wrap_pend;
	entry_t ent;
	logic   seen;
	logic   has_label;
	count_t new_count;
	order_t new_order;
	logic   take_best;
	label_t cur_label;
	count_t cur_count;

	always_comb begin
		cell_acc  = cells.valid && cells.ready;
		out_free  = !out_valid_q || result.ready;
		// The last cell of a set waits here while the previous result is held.
		advance   = valid_s1 && (!last_s1 || out_free);
		wrap_pend = valid_s1 && last_s1 && (ctrl.epoch == EPOCH_LAST);
		cells.ready = ctrl.run && !wrap_pend && (!valid_s1 || advance);

		rd_en   = cell_acc;
		rd_addr = cells.cell_label[LABEL_BITS-1:0];

		// The entry written in the previous cycle is not yet in the read data.
		ent       = (fwd_valid_q && fwd_label_q == label_s1) ? fwd_data_q : rd_data;
		seen      = (ent.epoch == ctrl.epoch);
		has_label = (label_s1 != '0);

		if (!seen) begin
			new_count = count_t'(1);
			new_order = next_order_q;
		end else begin
			new_count = (ent.count == COUNT_MAX) ? COUNT_MAX : count_t'(ent.count + 1'b1);
			new_order = ent.order;
		end

		take_best = has_label && ((new_count > best_count_q) ||
			(new_count == best_count_q && new_order < best_order_q));
		cur_label = take_best ? label_s1 : best_label_q;
		cur_count = take_best ? new_count : best_count_q;

		wr_req.we   = advance && has_label;
		wr_req.addr = label_s1;
		wr_req.data = '{epoch: ctrl.epoch, count: new_count, order: new_order};

		set_done = advance && last_s1;

		result.valid         = out_valid_q;
		result.largest_label = CELL_LABEL_W'(out_label_q);
		result.largest_count = out_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			fwd_valid_q  <= 1'b0;
			best_label_q <= '0;
			best_count_q <= '0;
			best_order_q <= '0;
			next_order_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cell_acc) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (!ctrl.run) begin
				fwd_valid_q <= 1'b0;
			end else if (wr_req.we) begin
				fwd_valid_q <= 1'b1;
			end

			if (advance) begin
				if (last_s1) begin
					best_label_q <= '0;
					best_count_q <= '0;
					best_order_q <= '0;
					next_order_q <= '0;
				end else begin
					if (take_best) begin
						best_label_q <= label_s1;
						best_count_q <= new_count;
						best_order_q <= new_order;
					end
					if (has_label && !seen) begin
						next_order_q <= next_order_q + 1'b1;
					end
				end
			end

			if (set_done) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cell_acc) begin
			label_s1 <= cells.cell_label[LABEL_BITS-1:0];
			last_s1  <= cells.last_cell;
		end
		if (wr_req.we) begin
			fwd_label_q <= wr_req.addr;
			fwd_data_q  <= wr_req.data;
		end
		if (set_done) begin
			out_label_q <= cur_label;
			out_count_q <= cur_count;
		end
	end

endmodule

[design/most_frequent_label_finder.sv]
// Most frequent label finder: histogram mode over a stream of grid cells.
// Channel "cells" carries one cell per transaction: cell_label (0 = empty,
// skipped) and last_cell, which closes the set. Channel "result" carries one
// transaction per set: largest_label and largest_count, with ties going to
// the label that first appeared earliest; an empty set yields 0 and 0.
// Throughput is one cell per cycle outside of stalls, set by the single
// read-modify-write of the per-label store (one read and one write port),
// with the entry written in one cycle forwarded to the next. A result is
// presented on the result channel from the output register, which is loaded
// when the last cell of its set leaves the update stage. While a result
// waits, cells keep flowing; only the next last cell holds in the update
// stage until the result is taken. Each set carries an epoch tag, so the
// store needs no clearing between sets. After reset, and after every 255th
// set, a sweep marks all entries stale; no cell is accepted during the sweep.
// Dependencies: mflf_pkg, mflf_ifs, mflf_label_ram, mflf_ctrl, mflf_tally.
module most_frequent_label_finder import mflf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	mflf_cell_if.sink     cells,
	mflf_result_if.source result
);

	ctrl_t   ctrl;
	wr_req_t clr_wr;
	wr_req_t tal_wr;
	wr_req_t ram_wr;
	logic    set_done;
	logic    rd_en;
	label_t  rd_addr;
	entry_t  rd_data;

	mflf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.set_done (set_done),
		.ctrl     (ctrl),
		.clr_wr   (clr_wr)
	);

	mflf_tally u_tally (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cells    (cells),
		.result   (result),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_req   (tal_wr),
		.set_done (set_done)
	);

	assign ram_wr = clr_wr.we ? clr_wr : tal_wr;

	mflf_label_ram u_ram (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

endmodule

[design/mflf_checker.sv]
// Port-level checks for the most frequent label finder, bound to the top.
// Depends on mflf_pkg for the field widths.
module mflf_checker import mflf_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    cells_valid,
	input logic                    cells_ready,
	input logic                    cells_last,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic [CELL_LABEL_W-1:0] res_label,
	input logic [COUNT_BITS-1:0]   res_count
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result transaction dropped before it was taken");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_label) && $stable(res_count))
		else $error("result payload changed while stalled");

	a_empty_pair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res_count == '0) == (res_label == '0)))
		else $error("label and count disagree on an empty set");

	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cells_valid && cells_ready && cells_last, 2))
		else $error("result appeared without a last cell two cycles earlier");

endmodule

bind most_frequent_label_finder mflf_checker u_mflf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cells_valid (cells.valid),
	.cells_ready (cells.ready),
	.cells_last  (cells.last_cell),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_label   (result.largest_label),
	.res_count   (result.largest_count)
);

[bench/most_frequent_label_finder_test.sv]
// Self-checking bench for most_frequent_label_finder: a directed table of label runs,
// then random sets, scored against a behavioral tally (typed rows: their own result).
// Depends on mflf_pkg, mflf_ifs and the RTL of the block.
module most_frequent_label_finder_test;
	import mflf_pkg::*;

	localparam int unsigned RANDOM_CELLS = 2000;
	localparam int unsigned QUIET_LIMIT  = 4 * 65536;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PLAN_LEN     = 20;

	typedef struct packed {
		label_t lab;
		count_t cnt;
	} outcome_t;

	// One row is a run of identical cells; closes puts last_cell on its final cell.
	typedef struct packed {
		label_t      lab;
		logic [19:0] reps;
		logic        closes;
		logic        typed;
		label_t      exp_lab;
		count_t      exp_cnt;
	} run_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_DUTY
	} rx_mode_t;

	localparam run_t PLAN [PLAN_LEN] = '{
		'{16'h0000, 20'd1,      1'b1, 1'b1, 16'h0000, 17'd0},
		'{16'hFFFF, 20'd1,      1'b1, 1'b1, 16'hFFFF, 17'd1},
		'{16'h0001, 20'd1,      1'b1, 1'b1, 16'h0001, 17'd1},
		'{16'h0000, 20'd5,      1'b0, 1'b0, 16'h0000, 17'd0},
		'{16'h0000, 20'd1,      1'b1, 1'b1, 16'h0000, 17'd0},
		'{16'h0005, 20'd3,      1'b0, 1'b0, 16'h0000, 17'd0},
		'{16'h0009, 20'd3,      1'b0, 1'b0, 16'h0000, 17'd0},
		'{16'h0000, 20'd1,      1'b1, 1'b0, 16'h0000, 17'd0},
		'{16'h0009, 20'd2,      1'b0, 1'b0, 16'h0000, 17'd0},
		'{16'h0005, 20'd2,      1'b0, 1'b0, 16'h0000, 17'd0},
		'{16'h0009, 20'd1,      1'b1, 1'b0, 16'h0000, 17'd0},
		'{16'h0002, 20'd1,      1'b0, 1'b0, 16'h0000, 17'd0},
		'{16'h0003, 20'd2,      1'b0, 1'b0, 16'h0000, 17'd0},
		'{16'h0002, 20'd1,      1'b1, 1'b0, 16'h0000, 17'd0},
		'{16'hAAAA, 20'd1,      1'b0, 1'b0, 16'h0000, 17'd0},
		'{16'h5555, 20'd2,      1'b1, 1'b0, 16'h0000, 17'd0},
		'{16'h0004, 20'd2,      1'b0, 1'b0, 16'h0000, 17'd0},
		'{16'h0000, 20'd1,      1'b1, 1'b0, 16'h0000, 17'd0},
		'{16'hFFFF, 20'd2,      1'b0, 1'b0, 16'h0000, 17'd0},
		'{16'h0001, 20'd2,      1'b1, 1'b0, 16'h0000, 17'd0}
	};

	logic clk;
	logic arst_n;

	mflf_cell_if   cells ();
	mflf_result_if result ();

	most_frequent_label_finder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cells  (cells),
		.result (result)
	);

	// Running histogram of the open set.
	count_t      tally [label_t];
	order_t      first_pos [label_t];
	int unsigned arrivals;
	label_t      lead_lab;
	count_t      lead_cnt;
	order_t      lead_pos;

	outcome_t    pending_winners [$];
	int unsigned cells_sent;
	int unsigned sets_closed;
	int unsigned results_checked;
	int unsigned mismatches;
	int unsigned burst_left;
	bit          no_gaps;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Folds one cell into the histogram; returns 1 with the winner when the set closes.
	function automatic bit tally_cell(label_t lab, logic closes, output outcome_t winner);
		count_t c;
		order_t p;
		if (lab != '0) begin
			if (!tally.exists(lab)) begin
				tally[lab] = count_t'(1);
				first_pos[lab] = order_t'(arrivals);
				arrivals++;
			end else if (tally[lab] != COUNT_MAX) begin
				tally[lab] = tally[lab] + count_t'(1);
			end
			c = tally[lab];
			p = first_pos[lab];
			// An equal count only takes the lead if the label showed up earlier.
			if (c > lead_cnt || (c == lead_cnt && p < lead_pos)) begin
				lead_lab = lab;
				lead_cnt = c;
				lead_pos = p;
			end
		end
		winner = '{lead_lab, lead_cnt};
		if (!closes)
			return 1'b0;
		tally.delete();
		first_pos.delete();
		arrivals = 0;
		lead_lab = '0;
		lead_cnt = '0;
		lead_pos = '0;
		return 1'b1;
	endfunction

	task automatic push_cell(label_t lab, logic closes, bit typed, outcome_t typed_res);
		int unsigned gap;
		outcome_t    guess;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 12);
			gap = no_gaps ? 0 : $urandom_range(0, 7);
			if (gap != 0) begin
				cells.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cells.valid      <= 1'b1;
		cells.cell_label <= lab;
		cells.last_cell  <= closes;
		do @(posedge clk); while (!cells.ready);
		cells_sent++;
		if (tally_cell(lab, closes, guess)) begin
			pending_winners.push_back(typed ? typed_res : guess);
			sets_closed++;
		end
	endtask

	// Hold the sender off until every open result has been collected.
	task automatic drain_results();
		if (pending_winners.size() != 0) begin
			cells.valid <= 1'b0;
			while (pending_winners.size() != 0) @(posedge clk);
		end
	endtask

	initial begin
		int unsigned random_cells;
		int unsigned n;
		int unsigned shape;
		int unsigned pool_size;
		label_t      pool [5];
		label_t      lab;

		arst_n           <= 1'b0;
		cells.valid      <= 1'b0;
		cells.cell_label <= '0;
		cells.last_cell  <= 1'b0;
		arrivals = 0;
		lead_lab = '0;
		lead_cnt = '0;
		lead_pos = '0;
		cells_sent = 0;
		sets_closed = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		random_cells = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[r]) begin
			no_gaps = PLAN[r].reps > 1000;
			for (int unsigned k = 1; k <= PLAN[r].reps; k++)
				push_cell(PLAN[r].lab, PLAN[r].closes && k == PLAN[r].reps, PLAN[r].typed,
					'{PLAN[r].exp_lab, PLAN[r].exp_cnt});
		end
		no_gaps = 1'b0;
		drain_results();

		// Small sets dominate so that enough sets pass to wrap the epoch counter.
		while (random_cells < RANDOM_CELLS) begin
			if ($urandom_range(0, 39) == 0)
				drain_results();
			shape = $urandom_range(0, 9);
			n = (shape == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
			pool_size = $urandom_range(1, 5);
			for (int unsigned j = 0; j < 5; j++)
				pool[j] = (shape == 1) ? label_t'($urandom_range(1, 15)) :
					label_t'($urandom_range(0, 65535));
			for (int unsigned i = 0; i < n; i++) begin
				if ($urandom_range(0, 4) == 0)
					lab = '0;
				else if (shape == 2)
					lab = label_t'($urandom_range(0, 65535));
				else
					lab = pool[$urandom_range(0, pool_size - 1)];
				push_cell(lab, i == n - 1, 1'b0, '0);
				random_cells++;
			end
		end

		cells.valid <= 1'b0;
		while (pending_winners.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d cells in %0d sets (%0d directed runs plus random sets).",
			cells_sent, sets_closed, PLAN_LEN);
		$display("Compared %0d results, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0 && pending_winners.size() == 0) begin
			$display("most_frequent_label_finder test passed");
		end else begin
			$display("most_frequent_label_finder test failed");
		end
		$finish;
	end

	// Result side stalls in phases of random length, each with its own pattern.
	initial begin
		int unsigned span;
		int unsigned phase;
		rx_mode_t    mode;
		span = 0;
		phase = 0;
		mode = RX_OPEN;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				span = $urandom_range(20, 300);
			end
			span--;
			phase++;
			case (mode)
				RX_OPEN:   result.ready <= 1'b1;
				RX_COIN:   result.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: result.ready <= (phase % 4 == 0);
				default:   result.ready <= (phase % 16 < 11);
			endcase
		end
	end

	initial begin
		results_checked = 0;
		mismatches = 0;
	end

	always @(posedge clk) begin
		outcome_t want;
		if (result.valid && result.ready) begin
			results_checked++;
			if (pending_winners.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected result transaction: label %0h count %0d",
						result.largest_label, result.largest_count);
				mismatches++;
			end else begin
				want = pending_winners.pop_front();
				if (want.lab != result.largest_label || want.cnt != result.largest_count) begin
					if (mismatches < 10)
						$display("Mismatch: expected label %0h count %0d, got label %0h count %0d",
							want.lab, want.cnt, result.largest_label, result.largest_count);
					mismatches++;
				end
			end
		end
	end

	// The stale sweep after reset and every 255th set stalls cells.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cells.valid && cells.ready) || (result.valid && result.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transaction for %0d cycles.", QUIET_LIMIT);
		$display("most_frequent_label_finder test failed");
		$finish;
	end

endmodule
